### design/rowwise_quantized_dequantizer_core_assert.svh
// Assertion macros used by the checker file rqd_checker.sv.
`ifndef ROWWISE_QUANTIZED_DEQUANTIZER_CORE_ASSERT_SVH
`define ROWWISE_QUANTIZED_DEQUANTIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RQD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rqd check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RQD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rqd check failed");

`endif

### design/rqd_pkg.sv
`default_nettype none

package rqd_pkg;

    // Mode register codes
    localparam logic [1:0] MODE_8 = 2'd0;
    localparam logic [1:0] MODE_4 = 2'd1;
    localparam logic [1:0] MODE_2 = 2'd2;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // One element on its way into the multiplier
    typedef struct packed {
        logic [7:0]  q;
        logic [31:0] scale;
        logic [31:0] bias;
        logic        last;
    } t_elem;

    // Rounded product on its way into the adder
    typedef struct packed {
        logic [31:0] value;
        logic [31:0] bias;
        logic        last;
    } t_prod;

    // Exact binary16 to binary32 widening
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] p;
        logic [9:0] fr;
        logic [7:0] e;
        ex  = h[14:10];
        man = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
        end
        fr = 10'(man << (4'd10 - p));
        e  = 8'd103 + {4'b0, p};
        if (ex == 5'h1F) return {h[15], 8'hFF, man, 13'b0};
        else if (ex != 5'd0) return {h[15], 8'({3'b0, ex} + 8'd112), man, 13'b0};
        else if (man == 10'd0) return {h[15], 31'b0};
        else return {h[15], e, fr, 13'b0};
    endfunction

    // Leading zeros of a nonzero 32-bit word
    function automatic logic [4:0] clz32(input logic [31:0] v);
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) lz = 5'(31 - i);
        end
        return lz;
    endfunction

    // Leading zeros of a nonzero 28-bit word
    function automatic logic [4:0] clz28(input logic [27:0] v);
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) lz = 5'(27 - i);
        end
        return lz;
    endfunction

    // Round to nearest even and pack. m has its leading one at bit 31 and
    // stands for 1.f * 2^(e-127); st collects bits below m.
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [10:0] e,
                                               input logic [31:0] m,
                                               input logic st);
        logic [10:0] sh;
        logic [5:0]  sh6;
        logic [63:0] w;
        logic [31:0] mm;
        logic [7:0]  ef;
        logic        s2;
        logic        rnd;
        logic [30:0] pk;
        sh  = 11'(11'sd1 - e);
        sh6 = (sh > 11'd63) ? 6'd63 : sh[5:0];
        w   = {m, 32'b0} >> sh6;
        if (e <= 11'sd0) begin
            mm = w[63:32];
            s2 = st | (|w[31:0]);
            ef = 8'd0;
        end else begin
            mm = m;
            s2 = st;
            ef = e[7:0];
        end
        rnd = mm[7] & ((|mm[6:0]) | s2 | mm[8]);
        pk  = {ef, mm[30:8]} + {30'b0, rnd};
        if (e >= 11'sd255) return {sign, 8'hFF, 23'b0};
        else return {sign, pk};
    endfunction

endpackage

`default_nettype wire

### design/rqd_unpack.sv
`default_nettype none

module rqd_unpack import rqd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_scale_bits,
    input  wire logic [31:0] i_bias_bits,
    input  wire logic [1:0]  i_bit_mode,
    output logic             o_stall,
    output logic             o_valid,
    output t_elem            o_elem
);

    logic        r_hold;
    logic [7:0]  r_byte;
    logic [31:0] r_scale;
    logic [31:0] r_bias;
    logic [1:0]  r_mode;
    logic [1:0]  r_idx;
    logic        r_out_v;
    t_elem       r_out;

    logic  w_last;
    logic  w_take;
    logic  w_done;
    logic  w_accept;
    t_elem n_out;

    // Element select for the held byte
    always_comb begin
        n_out       = '0;
        n_out.scale = r_scale;
        n_out.bias  = r_bias;
        case (r_mode)
            MODE_8: begin
                n_out.q = r_byte;
                w_last  = 1'b1;
            end
            MODE_4: begin
                n_out.q = {4'b0, (r_idx[0] ? r_byte[7:4] : r_byte[3:0])};
                w_last  = r_idx[0];
            end
            default: begin
                n_out.q = 8'(r_byte >> {r_idx, 1'b0}) & 8'h03;
                w_last  = (r_idx == 2'd3);
            end
        endcase
        n_out.last = w_last;
    end

    assign w_take   = r_hold & i_en;
    assign w_done   = w_take & w_last;
    assign o_stall  = r_hold & ~w_done;
    assign w_accept = i_valid & ~o_stall;

    // Byte holding register and element counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_accept) begin
            r_hold <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_done) begin
            r_hold <= 1'b0;
        end else if (w_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_data_byte;
            r_mode <= i_bit_mode;
            if (i_bit_mode == MODE_8) begin
                r_scale <= i_scale_bits;
                r_bias  <= i_bias_bits;
            end else begin
                r_scale <= half_to_single(i_scale_bits[15:0]);
                r_bias  <= half_to_single(i_bias_bits[15:0]);
            end
        end
    end

    // Element stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_elem  = r_out;

endmodule

`default_nettype wire

### design/rqd_fmul.sv
`default_nettype none

module rqd_fmul import rqd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_elem i_elem,
    output logic       o_valid,
    output t_prod      o_prod
);

    // Stage 1: integer product and operand class
    logic        r_m1_v;
    logic [31:0] r_m1_p;
    logic [7:0]  r_m1_e;
    logic        r_m1_sign;
    logic        r_m1_nan;
    logic        r_m1_inf;
    logic        r_m1_zero;
    logic [31:0] r_m1_bias;
    logic        r_m1_last;

    // Stage 2: normalized product
    logic               r_m2_v;
    logic [31:0]        r_m2_m;
    logic signed [10:0] r_m2_e;
    logic               r_m2_sign;
    logic               r_m2_nan;
    logic               r_m2_inf;
    logic               r_m2_zero;
    logic [31:0]        r_m2_bias;
    logic               r_m2_last;

    // Stage 3: rounded product
    logic  r_m3_v;
    t_prod r_m3;

    logic [7:0]  w_es;
    logic [22:0] w_fs;
    logic [23:0] w_mant;
    logic [4:0]  w_lz;
    t_prod       n_m3;

    assign w_es   = i_elem.scale[30:23];
    assign w_fs   = i_elem.scale[22:0];
    assign w_mant = {(w_es != 8'd0), w_fs};
    assign w_lz   = clz32(r_m1_p);

    always_comb begin
        n_m3.bias = r_m2_bias;
        n_m3.last = r_m2_last;
        if (r_m2_nan) n_m3.value = QNAN;
        else if (r_m2_inf) n_m3.value = {r_m2_sign, 8'hFF, 23'b0};
        else if (r_m2_zero) n_m3.value = {r_m2_sign, 31'b0};
        else n_m3.value = round_pack(r_m2_sign, r_m2_e, r_m2_m, 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
        end else if (i_en) begin
            r_m1_v <= i_valid;
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_p    <= {24'b0, i_elem.q} * {8'b0, w_mant};
            r_m1_e    <= (w_es == 8'd0) ? 8'd1 : w_es;
            r_m1_sign <= i_elem.scale[31];
            r_m1_nan  <= (w_es == 8'hFF) && ((w_fs != 23'd0) || (i_elem.q == 8'd0));
            r_m1_inf  <= (w_es == 8'hFF);
            r_m1_zero <= (i_elem.q == 8'd0) || (i_elem.scale[30:0] == 31'd0);
            r_m1_bias <= i_elem.bias;
            r_m1_last <= i_elem.last;

            r_m2_m    <= r_m1_p << w_lz;
            r_m2_e    <= $signed({3'b0, r_m1_e}) + 11'sd8 - $signed({6'b0, w_lz});
            r_m2_sign <= r_m1_sign;
            r_m2_nan  <= r_m1_nan;
            r_m2_inf  <= r_m1_inf;
            r_m2_zero <= r_m1_zero;
            r_m2_bias <= r_m1_bias;
            r_m2_last <= r_m1_last;

            r_m3 <= n_m3;
        end
    end

    assign o_valid = r_m3_v;
    assign o_prod  = r_m3;

endmodule

`default_nettype wire

### design/rqd_fadd.sv
`default_nettype none

module rqd_fadd import rqd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_prod i_prod,
    output logic        o_valid,
    output logic [31:0] o_value,
    output logic        o_last
);

    // Stage 1: swap by magnitude, exponent difference
    logic        r_a1_v;
    logic        r_a1_sx;
    logic [7:0]  r_a1_ex;
    logic [23:0] r_a1_mx;
    logic [23:0] r_a1_my;
    logic [7:0]  r_a1_d;
    logic        r_a1_sub;
    logic        r_a1_zs;
    logic        r_a1_nan;
    logic        r_a1_inf;
    logic        r_a1_is;
    logic        r_a1_last;

    // Stage 2: aligned sum
    logic        r_a2_v;
    logic [27:0] r_a2_s;
    logic [7:0]  r_a2_ex;
    logic        r_a2_sx;
    logic        r_a2_zs;
    logic        r_a2_nan;
    logic        r_a2_inf;
    logic        r_a2_is;
    logic        r_a2_last;

    // Stage 3: normalized sum
    logic               r_a3_v;
    logic [27:0]        r_a3_m;
    logic signed [10:0] r_a3_e;
    logic               r_a3_zero;
    logic               r_a3_sx;
    logic               r_a3_zs;
    logic               r_a3_nan;
    logic               r_a3_inf;
    logic               r_a3_is;
    logic               r_a3_last;

    // Stage 4: result register
    logic        r_a4_v;
    logic [31:0] r_a4_val;
    logic        r_a4_last;

    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic        w_a_nan;
    logic        w_b_nan;
    logic        w_a_inf;
    logic        w_b_inf;
    logic [7:0]  w_ex;
    logic [7:0]  w_ey;
    logic [53:0] w_sh;
    logic [26:0] w_ys;
    logic [26:0] w_xs;
    logic [4:0]  w_lz;
    logic [31:0] n_a4_val;

    assign w_a     = i_prod.value;
    assign w_b     = i_prod.bias;
    assign w_a_nan = (w_a[30:23] == 8'hFF) && (w_a[22:0] != 23'd0);
    assign w_b_nan = (w_b[30:23] == 8'hFF) && (w_b[22:0] != 23'd0);
    assign w_a_inf = (w_a[30:0] == 31'h7F80_0000);
    assign w_b_inf = (w_b[30:0] == 31'h7F80_0000);
    assign w_x     = (w_b[30:0] > w_a[30:0]) ? w_b : w_a;
    assign w_y     = (w_b[30:0] > w_a[30:0]) ? w_a : w_b;
    assign w_ex    = (w_x[30:23] == 8'd0) ? 8'd1 : w_x[30:23];
    assign w_ey    = (w_y[30:23] == 8'd0) ? 8'd1 : w_y[30:23];

    // Alignment with sticky folded into the lowest bit
    assign w_sh = {r_a1_my, 3'b0, 27'b0} >> r_a1_d;
    assign w_ys = {w_sh[53:28], w_sh[27] | (|w_sh[26:0])};
    assign w_xs = {r_a1_mx, 3'b0};

    assign w_lz = clz28(r_a2_s);

    always_comb begin
        if (r_a3_nan) n_a4_val = QNAN;
        else if (r_a3_inf) n_a4_val = {r_a3_is, 8'hFF, 23'b0};
        else if (r_a3_zero) n_a4_val = {r_a3_zs, 31'b0};
        else n_a4_val = round_pack(r_a3_sx, r_a3_e, {r_a3_m, 4'b0}, 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v <= 1'b0;
            r_a2_v <= 1'b0;
            r_a3_v <= 1'b0;
            r_a4_v <= 1'b0;
        end else if (i_en) begin
            r_a1_v <= i_valid;
            r_a2_v <= r_a1_v;
            r_a3_v <= r_a2_v;
            r_a4_v <= r_a3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1_sx   <= w_x[31];
            r_a1_ex   <= w_ex;
            r_a1_mx   <= {(w_x[30:23] != 8'd0), w_x[22:0]};
            r_a1_my   <= {(w_y[30:23] != 8'd0), w_y[22:0]};
            r_a1_d    <= w_ex - w_ey;
            r_a1_sub  <= w_x[31] ^ w_y[31];
            r_a1_zs   <= w_a[31] & w_b[31];
            r_a1_nan  <= w_a_nan || w_b_nan || (w_a_inf && w_b_inf && (w_a[31] != w_b[31]));
            r_a1_inf  <= w_a_inf || w_b_inf;
            r_a1_is   <= w_a_inf ? w_a[31] : w_b[31];
            r_a1_last <= i_prod.last;

            r_a2_s    <= r_a1_sub ? ({1'b0, w_xs} - {1'b0, w_ys})
                                  : ({1'b0, w_xs} + {1'b0, w_ys});
            r_a2_ex   <= r_a1_ex;
            r_a2_sx   <= r_a1_sx;
            r_a2_zs   <= r_a1_zs;
            r_a2_nan  <= r_a1_nan;
            r_a2_inf  <= r_a1_inf;
            r_a2_is   <= r_a1_is;
            r_a2_last <= r_a1_last;

            r_a3_m    <= r_a2_s << w_lz;
            r_a3_e    <= $signed({3'b0, r_a2_ex}) + 11'sd1 - $signed({6'b0, w_lz});
            r_a3_zero <= (r_a2_s == 28'd0);
            r_a3_sx   <= r_a2_sx;
            r_a3_zs   <= r_a2_zs;
            r_a3_nan  <= r_a2_nan;
            r_a3_inf  <= r_a2_inf;
            r_a3_is   <= r_a2_is;
            r_a3_last <= r_a2_last;

            r_a4_val  <= n_a4_val;
            r_a4_last <= r_a3_last;
        end
    end

    assign o_valid = r_a4_v;
    assign o_value = r_a4_val;
    assign o_last  = r_a4_last;

endmodule

`default_nettype wire

### design/rowwise_quantized_dequantizer_core.sv
// Row-wise dequantizer: each input beat carries one packed data byte with
// its row's scale and bias and yields 1, 2 or 4 binary32 output beats
// (q*scale rounded, then +bias rounded, nearest even, canonical NaN),
// according to the mode register (0: 8-bit codes, fp32 scale/bias;
// 1: 4-bit codes low nibble first; 2 or 3: 2-bit codes low bits first,
// fp16 scale/bias). Write the mode only while the block is empty. Results
// leave on one output channel at one per cycle while the output is not
// stalled; the arithmetic is a nine-register pipeline (byte hold, element,
// three multiply, four add stages) that takes an element every cycle
// unless stalled. Output stall freezes the whole pipeline.
`default_nettype none

module rowwise_quantized_dequantizer_core import rqd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_scale_bits,
    input  wire logic [31:0] i_bias_bits,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_value_bits,
    output logic             o_last_of_byte
);

    logic [1:0] r_bit_mode;
    logic       w_en;
    logic       w_el_v;
    t_elem      w_elem;
    logic       w_pr_v;
    t_prod      w_prod;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_mode <= MODE_8;
        end else if (i_cfg_we) begin
            r_bit_mode <= i_cfg_data;
        end
    end

    // Global advance: hold everything while the output beat is stalled
    assign w_en = ~(o_valid & i_stall);

    rqd_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_scale_bits (i_scale_bits),
        .i_bias_bits  (i_bias_bits),
        .i_bit_mode   (r_bit_mode),
        .o_stall      (o_stall),
        .o_valid      (w_el_v),
        .o_elem       (w_elem)
    );

    rqd_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_el_v),
        .i_elem  (w_elem),
        .o_valid (w_pr_v),
        .o_prod  (w_prod)
    );

    rqd_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pr_v),
        .i_prod  (w_prod),
        .o_valid (o_valid),
        .o_value (o_value_bits),
        .o_last  (o_last_of_byte)
    );

endmodule

`default_nettype wire

### design/rqd_checker.sv
`default_nettype none

`include "rowwise_quantized_dequantizer_core_assert.svh"

module rqd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_stall,
    input wire logic        o_valid,
    input wire logic [31:0] o_value_bits,
    input wire logic        o_last_of_byte
);

    // A stalled output beat holds
    `RQD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_value_bits) && $stable(o_last_of_byte))

    // NaN results are always the canonical quiet NaN
    `RQD_ASSERT_NOW(a_nan_canon, o_valid && (o_value_bits[30:23] == 8'hFF) && (o_value_bits[22:0] != 23'd0), o_value_bits == 32'h7FC0_0000)

    // Elements of one byte leave back to back
    `RQD_ASSERT_NEXT(a_byte_run, o_valid && !i_stall && !o_last_of_byte, o_valid)

endmodule

bind rowwise_quantized_dequantizer_core rqd_checker u_rqd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_stall        (i_stall),
    .o_valid        (o_valid),
    .o_value_bits   (o_value_bits),
    .o_last_of_byte (o_last_of_byte)
);

`default_nettype wire
